// ----- hdl/spcc_pkg.sv -----
// Shared types, codes and helpers for the sensor poll and calibrate controller.
// No dependencies; the design files refer to this package by scoped names, the testbench files import it.
package spcc_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_MEASURE   = 3'd1,
    OP_CALIBRATE = 3'd2,
    OP_PING      = 3'd3,
    OP_CHAR      = 3'd4,
    OP_PKT_END   = 3'd5,
    OP_READ      = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_DONE        = 2'd0,
    STAT_BUSY        = 2'd1,
    STAT_UNKNOWN     = 2'd2,
    STAT_UNSUPPORTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_MEASURE   = 2'd1,
    MODE_CALIBRATE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SEND_MEAS_REQ = 2'd0,
    SEND_PING     = 2'd1,
    SEND_PONG     = 2'd2
  } send_kind_e;

  // Received packet kinds
  localparam logic [7:0] PK_PING     = 8'd0;
  localparam logic [7:0] PK_PONG     = 8'd1;
  localparam logic [7:0] PK_MEAS_REQ = 8'd2;
  localparam logic [7:0] PK_MEAS_RSP = 8'd3;

  // Register index (word address bit 2 of paddr)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [7:0] TIMEOUT_RESET = 8'd1;

  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UF  = 8'h46;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LF  = 8'h66;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

  // Store access from the controller; idx is a sensor id, trimmed by the store
  typedef struct packed {
    logic        wr_en;
    logic        calib;
    logic        rd_en;
    logic [7:0]  idx;
    logic [31:0] reading;
    logic [31:0] stamp;
  } store_req_t;

  typedef struct packed {
    logic [31:0] reading;
    logic [31:0] stamp;
    logic [31:0] offset;
  } store_rsp_t;

  // Non-hex characters count as zero
  function automatic logic [3:0] hex_digit(logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = 4'(c - CHAR_0);
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = 4'(c - CHAR_UA) + DIGIT_TEN;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = 4'(c - CHAR_LA) + DIGIT_TEN;
    end
    return d;
  endfunction

endpackage

// ----- hdl/spcc_apb.sv -----
// Configuration port: APB-style slave holding the timeout register.
// Depends on spcc_pkg for the register index and reset value.
module spcc_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  timeout_o
);

  logic [7:0] timeout_q;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == spcc_pkg::REG_TIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= spcc_pkg::TIMEOUT_RESET;
    end else if (wr_hit) begin
      timeout_q <= pwdata[7:0];
    end
  end

  assign prdata    = (paddr[2] == spcc_pkg::REG_TIMEOUT) ? {24'd0, timeout_q} : 32'd0;
  assign timeout_o = timeout_q;

endmodule

// ----- hdl/spcc_store.sv -----
// Per-sensor storage: reading/time memory, offset memory, registered read.
// Valid bits stand in for the zero reset of both memories. Depends on spcc_pkg.
module spcc_store #(
  parameter int NUM_SENSORS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spcc_pkg::store_req_t   req_i,
  output spcc_pkg::store_rsp_t   rsp_o
);

  localparam int IdxW = $clog2(NUM_SENSORS);

  logic [63:0] sample_mem [NUM_SENSORS];
  logic [31:0] offset_mem [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] sample_vld_q;
  logic [NUM_SENSORS-1:0] offset_vld_q;

  logic [63:0]     sample_rd_q;
  logic [31:0]     offset_rd_q;
  logic            sample_hit_q;
  logic            offset_hit_q;
  logic [IdxW-1:0] idx;

  assign idx = req_i.idx[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      sample_mem[idx] <= {req_i.reading, req_i.stamp};
      if (req_i.calib) begin
        offset_mem[idx] <= req_i.reading;
      end
    end
    if (req_i.rd_en) begin
      sample_rd_q <= sample_mem[idx];
      offset_rd_q <= offset_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_vld_q <= '0;
      offset_vld_q <= '0;
      sample_hit_q <= 1'b0;
      offset_hit_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        sample_vld_q[idx] <= 1'b1;
        if (req_i.calib) begin
          offset_vld_q[idx] <= 1'b1;
        end
      end
      if (req_i.rd_en) begin
        sample_hit_q <= sample_vld_q[idx];
        offset_hit_q <= offset_vld_q[idx];
      end
    end
  end

  // Entries never written read as zero
  assign rsp_o.reading = sample_hit_q ? sample_rd_q[63:32] : 32'd0;
  assign rsp_o.stamp   = sample_hit_q ? sample_rd_q[31:0]  : 32'd0;
  assign rsp_o.offset  = offset_hit_q ? offset_rd_q        : 32'd0;

endmodule

// ----- hdl/spcc_ctrl.sv -----
// Item decoder, scalar state (mode, seconds, accumulator, flags) and result register.
// Drives the store through spcc_pkg::store_req_t; depends on spcc_pkg.
module spcc_ctrl #(
  parameter int NUM_SENSORS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            timeout_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            opcode_i,
  input  logic [7:0]            payload_char_i,
  input  logic [7:0]            packet_kind_i,
  input  logic [7:0]            packet_source_i,
  input  logic [2:0]            read_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  send_valid_o,
  output logic [1:0]            send_kind_o,
  output logic [1:0]            mode_now_o,
  output logic signed [31:0]    corrected_value_o,
  output logic [31:0]           sample_time_o,
  output logic [31:0]           offset_value_o,
  output spcc_pkg::store_req_t  store_req_o,
  input  spcc_pkg::store_rsp_t  store_rsp_i
);

  localparam int IdxW = $clog2(NUM_SENSORS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e                 st_q, st_d;
  spcc_pkg::mode_e        mode_q, mode_d;
  logic [31:0]            sec_q, sec_d;
  logic [31:0]            last_q, last_d;
  logic [31:0]            acc_q, acc_d;
  logic [NUM_SENSORS-1:0] cal_q, cal_d;

  logic                   out_valid_q;
  spcc_pkg::status_e      res_status_q, res_status;
  logic                   res_send_q, res_send;
  spcc_pkg::send_kind_e   res_kind_q, res_kind;
  spcc_pkg::mode_e        res_mode_q;
  logic [31:0]            corr_q, stime_q, offs_q;

  logic                   in_acc;
  logic                   go_read;
  logic                   busy;
  logic                   src_ok;
  logic                   ridx_ok;
  logic [31:0]            elapsed;
  logic [NUM_SENSORS-1:0] cal_set;
  logic                   all_cal;
  spcc_pkg::opcode_e      op;
  spcc_pkg::store_req_t   req;

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = spcc_pkg::opcode_e'(opcode_i);

  assign elapsed = sec_q - last_q;
  assign busy    = !(elapsed > {24'd0, timeout_i}) && (mode_q != spcc_pkg::MODE_IDLE);
  assign src_ok  = (packet_source_i != 8'd0) && (packet_source_i < 8'(NUM_SENSORS));
  assign ridx_ok = {5'd0, read_index_i} < 8'(NUM_SENSORS);
  assign cal_set = cal_q | (NUM_SENSORS'(1) << packet_source_i[IdxW-1:0]);
  assign all_cal = &cal_set[NUM_SENSORS-1:1];

  always_comb begin
    mode_d      = mode_q;
    sec_d       = sec_q;
    last_d      = last_q;
    acc_d       = acc_q;
    cal_d       = cal_q;
    res_status  = spcc_pkg::STAT_DONE;
    res_send    = 1'b0;
    res_kind    = spcc_pkg::SEND_MEAS_REQ;
    go_read     = 1'b0;
    req         = '0;
    if (in_acc) begin
      case (op)
        spcc_pkg::OP_TICK: begin
          sec_d = sec_q + 32'd1;
        end
        spcc_pkg::OP_MEASURE, spcc_pkg::OP_CALIBRATE, spcc_pkg::OP_PING: begin
          if (busy) begin
            res_status = spcc_pkg::STAT_BUSY;
          end else begin
            last_d   = sec_q;
            res_send = 1'b1;
            if (op == spcc_pkg::OP_MEASURE) begin
              mode_d = spcc_pkg::MODE_MEASURE;
            end else begin
              mode_d = spcc_pkg::MODE_CALIBRATE;
            end
            // Calibrate restarts every sensor but the master itself
            if (op == spcc_pkg::OP_CALIBRATE) begin
              cal_d = cal_q & {{(NUM_SENSORS-1){1'b0}}, 1'b1};
            end
            if (op == spcc_pkg::OP_PING) begin
              res_kind = spcc_pkg::SEND_PING;
            end
          end
        end
        spcc_pkg::OP_CHAR: begin
          acc_d = {acc_q[27:0], spcc_pkg::hex_digit(payload_char_i)};
        end
        spcc_pkg::OP_PKT_END: begin
          acc_d = 32'd0;
          case (packet_kind_i)
            spcc_pkg::PK_PING: begin
              res_send = 1'b1;
              res_kind = spcc_pkg::SEND_PONG;
            end
            spcc_pkg::PK_PONG, spcc_pkg::PK_MEAS_REQ: begin
              res_status = spcc_pkg::STAT_DONE;
            end
            spcc_pkg::PK_MEAS_RSP: begin
              if (!src_ok) begin
                res_status = spcc_pkg::STAT_UNKNOWN;
              end else begin
                req.wr_en   = 1'b1;
                req.idx     = packet_source_i;
                req.reading = acc_q;
                req.stamp   = sec_q;
                if (mode_q == spcc_pkg::MODE_CALIBRATE) begin
                  req.calib = 1'b1;
                  cal_d     = cal_set;
                  mode_d    = all_cal ? spcc_pkg::MODE_IDLE : spcc_pkg::MODE_CALIBRATE;
                end
              end
            end
            default: begin
              res_status = spcc_pkg::STAT_UNSUPPORTED;
            end
          endcase
        end
        spcc_pkg::OP_READ: begin
          if (!ridx_ok) begin
            res_status = spcc_pkg::STAT_UNKNOWN;
          end else begin
            req.rd_en = 1'b1;
            req.idx   = {5'd0, read_index_i};
            go_read   = 1'b1;
          end
        end
        default: begin
          res_status = spcc_pkg::STAT_UNSUPPORTED;
        end
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (go_read) begin
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mode_q      <= spcc_pkg::MODE_IDLE;
      sec_q       <= 32'd0;
      last_q      <= 32'd0;
      acc_q       <= 32'd0;
      cal_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mode_q <= mode_d;
      sec_q  <= sec_d;
      last_q <= last_d;
      acc_q  <= acc_d;
      cal_q  <= cal_d;
      if ((in_acc && !go_read) || (st_q == ST_READ)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; a read picks up the store data in the cycle after the request, in ST_READ
  always_ff @(posedge clk_i) begin
    if (in_acc && !go_read) begin
      res_status_q <= res_status;
      res_send_q   <= res_send;
      res_kind_q   <= res_kind;
      res_mode_q   <= mode_d;
      corr_q       <= 32'd0;
      stime_q      <= 32'd0;
      offs_q       <= 32'd0;
    end else if (st_q == ST_READ) begin
      res_status_q <= spcc_pkg::STAT_DONE;
      res_send_q   <= 1'b0;
      res_kind_q   <= spcc_pkg::SEND_MEAS_REQ;
      res_mode_q   <= mode_q;
      corr_q       <= store_rsp_i.reading - store_rsp_i.offset;
      stime_q      <= store_rsp_i.stamp;
      offs_q       <= store_rsp_i.offset;
    end
  end

  assign store_req_o       = req;
  assign out_valid_o       = out_valid_q;
  assign status_o          = res_status_q;
  assign send_valid_o      = res_send_q;
  assign send_kind_o       = res_kind_q;
  assign mode_now_o        = res_mode_q;
  assign corrected_value_o = $signed(corr_q);
  assign sample_time_o     = stime_q;
  assign offset_value_o    = offs_q;

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !go_read) |=> out_valid_q)
    else $error("result not registered after accepted beat");

  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_read |=> (st_q == ST_READ) && !in_ready_o)
    else $error("read did not hold the input while the store answers");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ) |=> out_valid_q && (st_q == ST_IDLE))
    else $error("read result not delivered");

  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.wr_en && req.rd_en) && (!req.calib || req.wr_en))
    else $error("conflicting store access");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != spcc_pkg::MODE_IDLE) && !in_acc |=> mode_q == $past(mode_q))
    else $error("mode changed without an accepted beat");

endmodule

// ----- hdl/sensor_poll_calibrate_controller.sv -----
// An accepted beat's result is registered; a sensor read also passes through the registered
// read of the synchronous store memories and the ST_READ state before its result is registered.
// Throughput: one beat a cycle while results are taken; a read holds the input while in ST_READ.
// Reset clears mode, counters, accumulator, calibrated flags and the store valid bits;
// unwritten store entries read as zero, so no clearing pass runs. Timeout resets to 1.
module sensor_poll_calibrate_controller #(
  parameter int NUM_SENSORS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         payload_char_i,
  input  logic [7:0]         packet_kind_i,
  input  logic [7:0]         packet_source_i,
  input  logic [2:0]         read_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               send_valid_o,
  output logic [1:0]         send_kind_o,
  output logic [1:0]         mode_now_o,
  output logic signed [31:0] corrected_value_o,
  output logic [31:0]        sample_time_o,
  output logic [31:0]        offset_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]           timeout;
  spcc_pkg::store_req_t store_req;
  spcc_pkg::store_rsp_t store_rsp;

  spcc_apb u_apb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  spcc_store #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  spcc_ctrl #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .timeout_i         (timeout),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .payload_char_i    (payload_char_i),
    .packet_kind_i     (packet_kind_i),
    .packet_source_i   (packet_source_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .send_valid_o      (send_valid_o),
    .send_kind_o       (send_kind_o),
    .mode_now_o        (mode_now_o),
    .corrected_value_o (corrected_value_o),
    .sample_time_o     (sample_time_o),
    .offset_value_o    (offset_value_o),
    .store_req_o       (store_req),
    .store_rsp_i       (store_rsp)
  );

endmodule

// ----- dv/spcc_checker.sv -----
// Checker for the sensor poll and calibrate controller: watches the item, result and
// register channels, predicts each result and compares it field by field.
// Depends on spcc_pkg for the opcode, status, mode and packet codes.
module spcc_checker #(
  parameter int NUM_SENSORS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         payload_char_i,
  input  logic [7:0]         packet_kind_i,
  input  logic [7:0]         packet_source_i,
  input  logic [2:0]         read_index_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic               send_valid_i,
  input  logic [1:0]         send_kind_i,
  input  logic [1:0]         mode_now_i,
  input  logic signed [31:0] corrected_value_i,
  input  logic [31:0]        sample_time_i,
  input  logic [31:0]        offset_value_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spcc_pkg::*;

  typedef struct packed {
    status_e     status;
    logic        send_valid;
    send_kind_e  send_kind;
    mode_e       mode_now;
    logic [31:0] corrected;
    logic [31:0] stamp;
    logic [31:0] offs;
  } poll_result_t;

  // Shadow of the controller state
  logic [7:0]             timeout_q;
  mode_e                  mode_q;
  logic [31:0]            seconds_q;
  logic [31:0]            last_req_q;
  logic [31:0]            hex_acc_q;
  logic [31:0]            reading_q [NUM_SENSORS];
  logic [31:0]            stamp_q   [NUM_SENSORS];
  logic [31:0]            offset_q  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] calibrated_q;

  poll_result_t expected_q[$];
  int           mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [3:0] char_nibble(logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return 4'(c - CHAR_0);
    if (c >= CHAR_UA && c <= CHAR_UF) return 4'(c - CHAR_UA + 8'd10);
    if (c >= CHAR_LA && c <= CHAR_LF) return 4'(c - CHAR_LA + 8'd10);
    return 4'd0;
  endfunction

  function automatic poll_result_t predict_poll(logic [2:0] op, logic [7:0] ch,
                                                logic [7:0] kind, logic [7:0] src,
                                                logic [2:0] idx);
    poll_result_t r;
    r.status     = STAT_DONE;
    r.send_valid = 1'b0;
    r.send_kind  = SEND_MEAS_REQ;
    r.corrected  = '0;
    r.stamp      = '0;
    r.offs       = '0;
    case (op)
      OP_TICK: seconds_q = seconds_q + 32'd1;
      OP_MEASURE, OP_CALIBRATE, OP_PING: begin
        // drop a stale request before the busy test
        if (seconds_q - last_req_q > 32'(timeout_q)) mode_q = MODE_IDLE;
        if (mode_q != MODE_IDLE) begin
          r.status = STAT_BUSY;
        end else begin
          if (op == OP_MEASURE) begin
            mode_q = MODE_MEASURE;
          end else begin
            mode_q = MODE_CALIBRATE;
            if (op == OP_CALIBRATE) calibrated_q[NUM_SENSORS-1:1] = '0;
            else r.send_kind = SEND_PING;
          end
          last_req_q   = seconds_q;
          r.send_valid = 1'b1;
        end
      end
      OP_CHAR: hex_acc_q = {hex_acc_q[27:0], char_nibble(ch)};
      OP_PKT_END: begin
        if (kind == PK_PING) begin
          r.send_valid = 1'b1;
          r.send_kind  = SEND_PONG;
        end else if (kind == PK_MEAS_RSP) begin
          if (src == 8'd0 || src >= NUM_SENSORS) begin
            r.status = STAT_UNKNOWN;
          end else begin
            reading_q[src] = hex_acc_q;
            stamp_q[src]   = seconds_q;
            if (mode_q == MODE_CALIBRATE) begin
              offset_q[src]     = hex_acc_q;
              calibrated_q[src] = 1'b1;
              if (&calibrated_q[NUM_SENSORS-1:1]) mode_q = MODE_IDLE;
            end
          end
        end else if (kind != PK_PONG && kind != PK_MEAS_REQ) begin
          r.status = STAT_UNSUPPORTED;
        end
        hex_acc_q = '0;
      end
      OP_READ: begin
        if (idx >= NUM_SENSORS) begin
          r.status = STAT_UNKNOWN;
        end else begin
          r.corrected = reading_q[idx] - offset_q[idx];
          r.stamp     = stamp_q[idx];
          r.offs      = offset_q[idx];
        end
      end
      default: r.status = STAT_UNSUPPORTED;
    endcase
    r.mode_now = mode_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    poll_result_t want;
    if (!rst_ni) begin
      timeout_q    = TIMEOUT_RESET;
      mode_q       = MODE_IDLE;
      seconds_q    = '0;
      last_req_q   = '0;
      hex_acc_q    = '0;
      calibrated_q = '0;
      foreach (reading_q[k]) begin
        reading_q[k] = '0;
        stamp_q[k]   = '0;
        offset_q[k]  = '0;
      end
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
        timeout_q = pwdata[7:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("send_valid", want.send_valid, send_valid_i);
          check_field("send_kind", want.send_kind, send_kind_i);
          check_field("mode_now", want.mode_now, mode_now_i);
          check_field("corrected_value", want.corrected, corrected_value_i);
          check_field("sample_time", want.stamp, sample_time_i);
          check_field("offset_value", want.offs, offset_value_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_poll(opcode_i, payload_char_i, packet_kind_i,
                                          packet_source_i, read_index_i));
      end
      pending_o <= expected_q.size();
    end
  end

  initial mismatches = 0;

endmodule

// ----- dv/tb_top.sv -----
// Top of the sensor poll and calibrate controller testbench: clock, reset, item and
// register stimulus, result back-pressure and the verdict.
// Depends on spcc_pkg, the controller RTL and spcc_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spcc_pkg::*;

  localparam int         NSENS        = 8;
  localparam logic [2:0] OP_RESERVED  = 3'd7;
  localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam int         NUM_PHASES   = 5;
  localparam int         PHASE_BEATS  = 125;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid;
  logic               in_ready;
  logic [2:0]         opcode;
  logic [7:0]         payload_char;
  logic [7:0]         packet_kind;
  logic [7:0]         packet_source;
  logic [2:0]         read_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic               send_valid;
  logic [1:0]         send_kind;
  logic [1:0]         mode_now;
  logic signed [31:0] corrected_value;
  logic [31:0]        sample_time;
  logic [31:0]        offset_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int beats_sent = 0;
  int settings   = 0;
  int idle_pct   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sensor_poll_calibrate_controller #(
    .NUM_SENSORS(NSENS)
  ) DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .payload_char_i   (payload_char),
    .packet_kind_i    (packet_kind),
    .packet_source_i  (packet_source),
    .read_index_i     (read_index),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .send_valid_o     (send_valid),
    .send_kind_o      (send_kind),
    .mode_now_o       (mode_now),
    .corrected_value_o(corrected_value),
    .sample_time_o    (sample_time),
    .offset_value_o   (offset_value),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  spcc_checker #(
    .NUM_SENSORS(NSENS)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (opcode),
    .payload_char_i   (payload_char),
    .packet_kind_i    (packet_kind),
    .packet_source_i  (packet_source),
    .read_index_i     (read_index),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .send_valid_i     (send_valid),
    .send_kind_i      (send_kind),
    .mode_now_i       (mode_now),
    .corrected_value_i(corrected_value),
    .sample_time_i    (sample_time),
    .offset_value_i   (offset_value),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Mostly hex digits of either case, now and then any byte at all
  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) return rnd8();
    if (d < 10) return CHAR_0 + 8'(d);
    return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(d - 10);
  endfunction

  task automatic send_beat(logic [2:0] op, logic [7:0] ch, logic [7:0] kind,
                           logic [7:0] src, logic [2:0] idx);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    payload_char  <= ch;
    packet_kind   <= kind;
    packet_source <= src;
    read_index    <= idx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_simple(logic [2:0] op);
    send_beat(op, rnd8(), rnd8(), rnd8(), 3'($urandom));
  endtask

  task automatic send_pkt_end(logic [7:0] kind, logic [7:0] src);
    send_beat(OP_PKT_END, rnd8(), kind, src, 3'($urandom));
  endtask

  // Payload characters followed by the end of a measure response
  task automatic send_response(logic [7:0] src);
    int ndig;
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
    repeat (ndig) send_beat(OP_CHAR, hex_char(), rnd8(), rnd8(), 3'($urandom));
    send_pkt_end(PK_MEAS_RSP, src);
  endtask

  task automatic calibration_sweep();
    int order[NSENS-1];
    int j;
    int t;
    for (int k = 0; k < NSENS - 1; k++) order[k] = k + 1;
    for (int k = NSENS - 2; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    send_simple($urandom_range(0, 1) ? OP_CALIBRATE : OP_PING);
    foreach (order[k]) begin
      if ($urandom_range(0, 9) == 0) send_simple($urandom_range(0, 1) ? OP_TICK : OP_READ);
      // skip a sensor now and then so calibration stays pending
      if ($urandom_range(0, 19) != 0) send_response(8'(order[k]));
    end
  endtask

  task automatic measure_round();
    logic [7:0] src;
    src = ($urandom_range(0, 9) == 0) ? rnd8() : 8'($urandom_range(1, NSENS - 1));
    send_simple(OP_MEASURE);
    repeat ($urandom_range(0, 2)) send_simple(OP_TICK);
    send_response(src);
    if ($urandom_range(0, 1)) send_beat(OP_READ, rnd8(), rnd8(), rnd8(), 3'(src));
  endtask

  // Hold the sender until every expected result is back or the guard runs out, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  // Result back-pressure in random bursts
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("sensor_poll_calibrate_controller test failed");
    $finish;
  end

  initial begin
    logic [7:0] dir_chars[$];
    logic [7:0] tmo;
    int         phase_end;
    int         pick;
    dir_chars = '{CHAR_0, CHAR_9, CHAR_LA, CHAR_LF, CHAR_UA, CHAR_UF, 8'h67, 8'h00, 8'hFF};
    in_valid      <= 1'b0;
    opcode        <= OP_TICK;
    payload_char  <= '0;
    packet_kind   <= '0;
    packet_source <= '0;
    read_index    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: busy refusal, timeout release, every packet kind, edge characters
    idle_pct = 20;
    send_simple(OP_TICK);
    send_simple(OP_MEASURE);
    send_simple(OP_PING);
    send_simple(OP_TICK);
    send_simple(OP_TICK);
    send_simple(OP_PING);
    send_pkt_end(PK_PING, rnd8());
    send_pkt_end(PK_PONG, rnd8());
    send_pkt_end(PK_MEAS_REQ, rnd8());
    send_pkt_end(8'd4, rnd8());
    send_pkt_end(8'hFF, rnd8());
    foreach (dir_chars[k]) send_beat(OP_CHAR, dir_chars[k], rnd8(), rnd8(), 3'($urandom));
    send_pkt_end(PK_MEAS_RSP, 8'd0);
    send_pkt_end(PK_MEAS_RSP, 8'(NSENS));
    send_beat(OP_CHAR, CHAR_UF, rnd8(), rnd8(), 3'($urandom));
    send_pkt_end(PK_MEAS_RSP, 8'(NSENS - 1));
    send_beat(OP_READ, rnd8(), rnd8(), rnd8(), 3'(NSENS - 1));
    send_beat(OP_READ, rnd8(), rnd8(), rnd8(), 3'd0);
    send_simple(OP_RESERVED);
    send_simple(OP_CALIBRATE);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0:       tmo = 8'd0;
        1:       tmo = 8'd255;
        2:       tmo = 8'd2;
        3:       tmo = 8'($urandom_range(3, 254));
        default: tmo = 8'd1;
      endcase
      write_timeout(tmo);
      // no idling at all in the closing phase
      if (phase == NUM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        pick     = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      end
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          calibration_sweep();
        end else if (pick < 45) begin
          measure_round();
        end else if (pick < 60) begin
          repeat ($urandom_range(1, 4)) send_simple(OP_TICK);
        end else if (pick < 75) begin
          repeat ($urandom_range(1, 3)) send_simple(OP_READ);
        end else begin
          send_beat(3'($urandom), rnd8(), rnd8(), rnd8(), 3'($urandom));
        end
      end
    end

    drain();
    if (pending != 0) $error("%0d results still outstanding", pending);
    $display("Drove %0d beats over %0d timeout settings: measure and calibration rounds,",
             beats_sent, settings);
    $display("busy refusals, timeouts, reads, malformed packets and result back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("sensor_poll_calibrate_controller test passed");
    end else begin
      $display("sensor_poll_calibrate_controller test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spcc_pkg.sv
hdl/spcc_apb.sv
hdl/spcc_store.sv
hdl/spcc_ctrl.sv
hdl/sensor_poll_calibrate_controller.sv
dv/spcc_checker.sv
dv/tb_top.sv
